### hdl/slx_pkg.sv
// Shared types, character classes and the per-byte lexing step for the source text lexer.
package slx_pkg;

    localparam int LINE_BITS  = 16;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 8 + LINE_BITS;
    localparam int OUT_USER_W = 5;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [LINE_BITS-1:0] line_t;
    localparam line_t LINE_ONE = line_t'(1);
    localparam line_t LINE_MAX = '1;

    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_NL     = 8'h0A;

    localparam logic [2:0] CLS_WORD    = 3'd0;
    localparam logic [2:0] CLS_NUMBER  = 3'd1;
    localparam logic [2:0] CLS_STRING  = 3'd2;
    localparam logic [2:0] CLS_OPER    = 3'd3;
    localparam logic [2:0] CLS_SINGLE  = 3'd4;
    localparam logic [2:0] CLS_COMMENT = 3'd5;
    localparam logic [2:0] CLS_SPACE   = 3'd6;

    localparam logic [1:0] PUSH_NONE = 2'd0;
    localparam logic [1:0] PUSH_ONE  = 2'd1;
    localparam logic [1:0] PUSH_TWO  = 2'd2;

    typedef enum logic [9:0] {
        M_BETWEEN = 10'b00_0000_0001,
        M_WORD    = 10'b00_0000_0010,
        M_NUMBER  = 10'b00_0000_0100,
        M_SQUOTE  = 10'b00_0000_1000,
        M_DQUOTE  = 10'b00_0001_0000,
        M_OPER    = 10'b00_0010_0000,
        M_COPEN   = 10'b00_0100_0000,
        M_CBODY   = 10'b00_1000_0000,
        M_CSTAR   = 10'b01_0000_0000,
        M_SPACE   = 10'b10_0000_0000
    } mode_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [2:0] token_class;
        logic       token_start;
        line_t      line_number;
        logic       text_end;
        logic       run_last;
    } res_t;

    // Results produced by one accepted item; w0 is delivered first.
    typedef struct packed {
        logic [1:0] n;
        res_t       w0;
        res_t       w1;
    } push_t;

    typedef struct packed {
        mode_t      mode;
        line_t      line;
        logic [2:0] cls;
        logic       start;
    } emit_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return is_digit(c) || ((c >= 8'h61) && (c <= 8'h7A))
            || ((c >= 8'h41) && (c <= 8'h5A)) || (c == 8'h5F);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    function automatic logic is_oper(input logic [7:0] c);
        return (c == 8'h7C) || (c == 8'h3C) || (c == 8'h3E) || (c == 8'h26)
            || (c == 8'h21) || (c == 8'h25) || (c == 8'h5E) || (c == CH_STAR)
            || (c == 8'h2D) || (c == 8'h2B) || (c == 8'h3D) || (c == CH_SLASH)
            || (c == CH_DOT) || (c == 8'h2C);
    endfunction

    // Classify one byte against the running token, with optional lookahead.
    function automatic emit_t lex_emit(input logic [7:0] c, input logic [7:0] la,
                                       input logic la_ok, input mode_t mode,
                                       input line_t line);
        emit_t e;
        logic  cont;
        e.cls   = CLS_SINGLE;
        e.start = 1'b0;
        e.mode  = mode;
        e.line  = line;
        cont    = 1'b1;
        unique case (mode)
            M_WORD:
            begin
                if (is_word(c)) e.cls = CLS_WORD; else cont = 1'b0;
            end
            M_NUMBER:
            begin
                if (is_digit(c)) e.cls = CLS_NUMBER; else cont = 1'b0;
            end
            M_OPER:
            begin
                if (is_oper(c)) e.cls = CLS_OPER; else cont = 1'b0;
            end
            M_SPACE:
            begin
                if (is_space(c)) e.cls = CLS_SPACE; else cont = 1'b0;
            end
            M_SQUOTE:
            begin
                e.cls = CLS_STRING;
                if (c == CH_SQUOTE) e.mode = M_BETWEEN;
            end
            M_DQUOTE:
            begin
                e.cls = CLS_STRING;
                if (c == CH_DQUOTE) e.mode = M_BETWEEN;
            end
            M_COPEN:
            begin
                e.cls  = CLS_COMMENT;
                e.mode = M_CBODY;
            end
            M_CBODY:
            begin
                e.cls = CLS_COMMENT;
                if (c == CH_STAR) e.mode = M_CSTAR;
            end
            M_CSTAR:
            begin
                e.cls = CLS_COMMENT;
                if (c == CH_SLASH) e.mode = M_BETWEEN;
                else if (c != CH_STAR) e.mode = M_CBODY;
            end
            default:
            begin
                cont = 1'b0;
            end
        endcase

        if (!cont)
        begin
            e.start = 1'b1;
            if (c == CH_SLASH && la_ok && la == CH_STAR)
            begin
                e.cls = CLS_COMMENT; e.mode = M_COPEN;
            end
            else if (is_space(c))
            begin
                e.cls = CLS_SPACE; e.mode = M_SPACE;
            end
            else if (is_word(c))
            begin
                e.cls = CLS_WORD; e.mode = M_WORD;
            end
            else if (c == CH_DOT && la_ok && is_digit(la))
            begin
                e.cls = CLS_NUMBER; e.mode = M_NUMBER;
            end
            else if (c == CH_SQUOTE)
            begin
                e.cls = CLS_STRING; e.mode = M_SQUOTE;
            end
            else if (c == CH_DQUOTE)
            begin
                e.cls = CLS_STRING; e.mode = M_DQUOTE;
            end
            else if (is_oper(c))
            begin
                e.cls = CLS_OPER; e.mode = M_OPER;
            end
            else
            begin
                e.cls = CLS_SINGLE; e.mode = M_BETWEEN;
            end
        end

        // Saturating line count.
        if (c == CH_NL && line != LINE_MAX)
            e.line = line + LINE_ONE;
        return e;
    endfunction

endpackage

### hdl/source_text_lexer.sv
// Top level of the source text lexer: byte stream in, tagged byte stream out.
//
//  channel  | dir | handshake                  | payload
//  ---------+-----+----------------------------+-----------------------------------------
//  s_axis   | in  | s_axis_tvalid/s_axis_tready | tdata = in_byte, tlast = is_final
//  m_axis   | out | m_axis_tvalid/m_axis_tready | tdata = out_byte, line_number;
//           |     |                            | tuser = token_class, token_start, text_end;
//           |     |                            | tlast = run_last
//
// One item per cycle while the queue has room: each accepted item classifies the byte
// held from the previous item, with the new byte as lookahead, and a final item
// also classifies its own byte with none; the results land in a four-entry queue.
// A non-final item yields at most one result, the final item of a text up to two,
// so the sustained rate is one item per cycle while the output side keeps up.
// Reset clears the held byte, the token mode and sets the line count to one;
// after a final item the lexer returns to that state by itself.
// s_axis_tready drops only when the queue could not take two more results, so a
// stalled output side blocks the input once three or four results wait.
module source_text_lexer (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [slx_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // [7:0] in_byte
    input  logic                              s_axis_tlast,  // is_final
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [slx_pkg::OUT_DATA_W-1:0]    m_axis_tdata,  // [7:0] out_byte, [23:8] line_number
    output logic [slx_pkg::OUT_USER_W-1:0]    m_axis_tuser,  // [2:0] token_class,
                                                             // [3] token_start, [4] text_end
    output logic                              m_axis_tlast   // run_last
);
    import slx_pkg::*;

    push_t push;
    res_t  out_res;

    // Classify the byte and advance the lexer state.
    slx_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_byte  (s_axis_tdata),
        .in_final (s_axis_tlast),
        .push     (push)
    );

    // Hold results until the downstream side takes them.
    slx_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    assign m_axis_tdata = {out_res.line_number, out_res.out_byte};
    assign m_axis_tuser = {out_res.text_end, out_res.token_start, out_res.token_class};
    assign m_axis_tlast = out_res.run_last;

endmodule

### hdl/slx_core.sv
// Lexer state registers and the combinational step for one accepted byte.
module slx_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic [7:0]          in_byte,
    input  logic                in_final,
    output slx_pkg::push_t      push
);
    import slx_pkg::*;

    logic [7:0] held_byte_reg, held_byte_next;
    logic       held_valid_reg, held_valid_next;
    mode_t      mode_reg, mode_next;
    line_t      line_reg, line_next;

    logic       accept;
    emit_t      e0;
    emit_t      e1;
    mode_t      mid_mode;
    line_t      mid_line;
    res_t       r0;
    res_t       r1;

    assign accept = in_valid && in_ready;

    // Held byte uses the incoming byte as lookahead; a final byte has none.
    always_comb
    begin
        e0       = lex_emit(held_byte_reg, in_byte, 1'b1, mode_reg, line_reg);
        mid_mode = held_valid_reg ? e0.mode : mode_reg;
        mid_line = held_valid_reg ? e0.line : line_reg;
        e1       = lex_emit(in_byte, 8'h00, 1'b0, mid_mode, mid_line);

        r0.out_byte    = held_byte_reg;
        r0.token_class = e0.cls;
        r0.token_start = e0.start;
        r0.line_number = e0.line;
        r0.text_end    = 1'b0;
        r0.run_last    = !in_final;

        r1.out_byte    = in_byte;
        r1.token_class = e1.cls;
        r1.token_start = e1.start;
        r1.line_number = e1.line;
        r1.text_end    = 1'b1;
        r1.run_last    = 1'b1;

        push.w0 = held_valid_reg ? r0 : r1;
        push.w1 = r1;
        if (!accept)
            push.n = PUSH_NONE;
        else if (held_valid_reg && in_final)
            push.n = PUSH_TWO;
        else if (held_valid_reg || in_final)
            push.n = PUSH_ONE;
        else
            push.n = PUSH_NONE;
    end

    always_comb
    begin
        held_byte_next  = held_byte_reg;
        held_valid_next = held_valid_reg;
        mode_next       = mode_reg;
        line_next       = line_reg;
        if (accept)
        begin
            if (in_final)
            begin
                held_byte_next  = 8'h00;
                held_valid_next = 1'b0;
                mode_next       = M_BETWEEN;
                line_next       = LINE_ONE;
            end
            else
            begin
                held_byte_next  = in_byte;
                held_valid_next = 1'b1;
                mode_next       = mid_mode;
                line_next       = mid_line;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_byte_reg  <= 8'h00;
            held_valid_reg <= 1'b0;
            mode_reg       <= M_BETWEEN;
            line_reg       <= LINE_ONE;
        end
        else
        begin
            held_byte_reg  <= held_byte_next;
            held_valid_reg <= held_valid_next;
            mode_reg       <= mode_next;
            line_reg       <= line_next;
        end
    end

endmodule

### hdl/slx_outq.sv
// Four-entry result queue: takes up to two results a cycle, delivers one when the output is ready.
module slx_outq (
    input  logic                clk,
    input  logic                rst_n,
    input  slx_pkg::push_t      push,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output slx_pkg::res_t       out_res
);
    import slx_pkg::*;

    res_t               q_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               pop;
    logic [QPTR_W-1:0]  wr_ptr_inc;

    assign pop        = out_valid && out_ready;
    assign out_valid  = (count_reg != '0);
    assign out_res    = q_reg[rd_ptr_reg];
    // Room for two more results whatever happens at the output.
    assign in_ready   = (count_reg <= QCNT_W'(QUEUE_DEPTH - 2));
    assign wr_ptr_inc = wr_ptr_reg + QPTR_W'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(push.n);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
        count_next  = count_reg + QCNT_W'(push.n) - QCNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.n != PUSH_NONE)
            q_reg[wr_ptr_reg] <= push.w0;
        if (push.n == PUSH_TWO)
            q_reg[wr_ptr_inc] <= push.w1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("result queue overflow");

    a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push.n != PUSH_NONE) |-> in_ready)
        else $error("results pushed while queue lacks room");

    a_push_code: assert property (@(posedge clk) disable iff (!rst_n)
        push.n <= PUSH_TWO)
        else $error("bad push count");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && push.n == PUSH_NONE) |=> (count_reg == $past(count_reg) - QCNT_W'(1)))
        else $error("queue count did not drop on delivery");

endmodule

### dv/tb_source_text_lexer.sv
// Self-checking testbench for the source text lexer: token stream scoreboard and stimulus.
`timescale 1ns / 1ps

import slx_pkg::*;

// Tracks the lexer state the same way the block should, and keeps the tagged bytes that
// each accepted item is due to produce, oldest first.
class tag_scoreboard;
    logic [7:0] held_ch;
    bit         held_ok;
    mode_t      lex_state;
    line_t      line_cnt;
    res_t       due_tags[$];
    int         errors;

    function new();
        errors = 0;
        restart();
    endfunction

    function void restart();
        held_ch   = 8'h00;
        held_ok   = 1'b0;
        lex_state = M_BETWEEN;
        line_cnt  = LINE_ONE;
    endfunction

    function bit digit_ch(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function bit ident_ch(logic [7:0] c);
        return digit_ch(c) || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function bit blank_ch(logic [7:0] c);
        return c == " " || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function bit op_ch(logic [7:0] c);
        case (c)
            "|", "<", ">", "&", "!", "%", "^", "*", "-", "+", "=", "/", ".", ",":
                return 1'b1;
            default:
                return 1'b0;
        endcase
    endfunction

    // Tag one byte against the running token; la is the following byte when la_ok is set.
    function res_t tag_byte(logic [7:0] c, logic [7:0] la, bit la_ok, bit at_end);
        res_t r;
        bit   keep_going;
        r             = '0;
        r.out_byte    = c;
        r.token_class = CLS_SINGLE;
        keep_going    = 1'b1;
        case (lex_state)
            M_WORD:
            begin
                if (ident_ch(c)) r.token_class = CLS_WORD; else keep_going = 1'b0;
            end
            M_NUMBER:
            begin
                if (digit_ch(c)) r.token_class = CLS_NUMBER; else keep_going = 1'b0;
            end
            M_OPER:
            begin
                if (op_ch(c)) r.token_class = CLS_OPER; else keep_going = 1'b0;
            end
            M_SPACE:
            begin
                if (blank_ch(c)) r.token_class = CLS_SPACE; else keep_going = 1'b0;
            end
            M_SQUOTE:
            begin
                r.token_class = CLS_STRING;
                if (c == CH_SQUOTE) lex_state = M_BETWEEN;
            end
            M_DQUOTE:
            begin
                r.token_class = CLS_STRING;
                if (c == CH_DQUOTE) lex_state = M_BETWEEN;
            end
            M_COPEN:
            begin
                r.token_class = CLS_COMMENT;
                lex_state     = M_CBODY;
            end
            M_CBODY:
            begin
                r.token_class = CLS_COMMENT;
                if (c == CH_STAR) lex_state = M_CSTAR;
            end
            M_CSTAR:
            begin
                r.token_class = CLS_COMMENT;
                if (c == CH_SLASH) lex_state = M_BETWEEN;
                else if (c != CH_STAR) lex_state = M_CBODY;
            end
            default:
            begin
                keep_going = 1'b0;
            end
        endcase

        if (!keep_going)
        begin
            r.token_start = 1'b1;
            if (c == CH_SLASH && la_ok && la == CH_STAR)
            begin
                r.token_class = CLS_COMMENT; lex_state = M_COPEN;
            end
            else if (blank_ch(c))
            begin
                r.token_class = CLS_SPACE; lex_state = M_SPACE;
            end
            else if (ident_ch(c))
            begin
                r.token_class = CLS_WORD; lex_state = M_WORD;
            end
            else if (c == CH_DOT && la_ok && digit_ch(la))
            begin
                r.token_class = CLS_NUMBER; lex_state = M_NUMBER;
            end
            else if (c == CH_SQUOTE)
            begin
                r.token_class = CLS_STRING; lex_state = M_SQUOTE;
            end
            else if (c == CH_DQUOTE)
            begin
                r.token_class = CLS_STRING; lex_state = M_DQUOTE;
            end
            else if (op_ch(c))
            begin
                r.token_class = CLS_OPER; lex_state = M_OPER;
            end
            else
            begin
                r.token_class = CLS_SINGLE; lex_state = M_BETWEEN;
            end
        end

        if (c == CH_NL && line_cnt != LINE_MAX)
            line_cnt = line_cnt + LINE_ONE;
        r.line_number = line_cnt;
        r.text_end    = at_end;
        r.run_last    = 1'b0;
        return r;
    endfunction

    // Account for one accepted input item.
    function void note_input(logic [7:0] c, bit fin);
        res_t r;
        if (held_ok)
        begin
            r = tag_byte(held_ch, c, 1'b1, 1'b0);
            r.run_last = !fin;
            due_tags.push_back(r);
        end
        if (fin)
        begin
            r = tag_byte(c, 8'h00, 1'b0, 1'b1);
            r.run_last = 1'b1;
            due_tags.push_back(r);
            restart();
        end
        else
        begin
            held_ch = c;
            held_ok = 1'b1;
        end
    endfunction

    function void match_field(string name, int exp_v, int got_v);
        if (exp_v != got_v)
        begin
            errors++;
            if (errors <= 100)
                $error("%s: expected %0d, actual %0d", name, exp_v, got_v);
        end
    endfunction

    // Compare one accepted output item with the oldest tag still due.
    function void check_result(logic [OUT_DATA_W-1:0] data, logic [OUT_USER_W-1:0] user,
                               logic last);
        res_t e;
        if (due_tags.size() == 0)
        begin
            errors++;
            $error("unexpected output item: out_byte %0d", data[7:0]);
            return;
        end
        e = due_tags.pop_front();
        match_field("out_byte", e.out_byte, data[7:0]);
        match_field("line_number", e.line_number, data[8 +: LINE_BITS]);
        match_field("token_class", e.token_class, user[2:0]);
        match_field("token_start", e.token_start, user[3]);
        match_field("text_end", e.text_end, user[4]);
        match_field("run_last", e.run_last, last);
    endfunction

    function int pending();
        return due_tags.size();
    endfunction
endclass

module tb_source_text_lexer;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;    // [7:0] in_byte
    logic                  s_axis_tlast;    // is_final
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;    // [7:0] out_byte, [23:8] line_number
    logic [OUT_USER_W-1:0] m_axis_tuser;    // [2:0] token_class, [3] token_start, [4] text_end
    logic                  m_axis_tlast;    // run_last

    tag_scoreboard lexsb = new();

    // Random idle bursts on both sides while set; cleared for the closing part of the run.
    bit gaps_on = 1'b1;
    int bytes_sent = 0;

    // Text under construction, sent as one stream with tlast on its final byte.
    logic [7:0] text_buf[$];

    source_text_lexer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Offer one item, possibly after an idle burst, and hold it until the lexer takes it.
    // Called right after a rising edge; returns right after the accepting edge.
    task automatic push_byte(input logic [7:0] c, input bit fin);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'($urandom);
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= fin;
        do
            @(posedge clk);
        while (!s_axis_tready);
        lexsb.note_input(c, fin);
        bytes_sent++;
    endtask

    task automatic send_buf();
        for (int i = 0; i < text_buf.size(); i++)
            push_byte(text_buf[i], i == text_buf.size() - 1);
    endtask

    task automatic send_text(input string s);
        text_buf.delete();
        for (int i = 0; i < s.len(); i++)
            text_buf.push_back(s[i]);
        send_buf();
    endtask

    function automatic logic [7:0] pick(input string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    // Append one plausible token (or noise) to the text buffer.
    task automatic add_token();
        int kind;
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1:
            begin
                repeat ($urandom_range(1, 6))
                    text_buf.push_back(pick("abzAZ_09xyQ7"));
            end
            2:
            begin
                text_buf.push_back(CH_DOT);
                repeat ($urandom_range(0, 4)) text_buf.push_back(pick("0123456789"));
            end
            3:
            begin
                // Quoted string; leave it open now and then so it runs to the end.
                logic [7:0] q;
                q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
                text_buf.push_back(q);
                repeat ($urandom_range(0, 5)) text_buf.push_back(pick("ab 1\n/*'\"."));
                if ($urandom_range(0, 7) != 0) text_buf.push_back(q);
            end
            4:
            begin
                repeat ($urandom_range(1, 4)) text_buf.push_back(pick("|<>&!%^*-+=/.,;"));
            end
            5:
            begin
                // Comment with stars and slashes inside; close it most of the time.
                text_buf.push_back(CH_SLASH);
                text_buf.push_back(CH_STAR);
                repeat ($urandom_range(0, 6)) text_buf.push_back(pick("ab**//\n "));
                if ($urandom_range(0, 7) != 0)
                begin
                    text_buf.push_back(CH_STAR);
                    text_buf.push_back(CH_SLASH);
                end
            end
            6:
            begin
                repeat ($urandom_range(1, 3)) text_buf.push_back(pick(" \t\n\n\f\r"));
            end
            7:
            begin
                text_buf.push_back(pick("(){}[]#@$?~`:\\"));
            end
            default:
            begin
                text_buf.push_back(8'($urandom));
            end
        endcase
    endtask

    // Output side: check every accepted item and stall in random bursts.
    initial
    begin
        int stall_left;
        stall_left    = 0;
        m_axis_tready = 1'b1;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
                lexsb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
            if (stall_left > 0)
            begin
                stall_left--;
                if (stall_left == 0) m_axis_tready <= 1'b1;
            end
            else if (gaps_on && $urandom_range(0, 5) == 0)
            begin
                stall_left    = $urandom_range(1, 8);
                m_axis_tready <= 1'b0;
            end
        end
    end

    // Main sequence: reset, directed texts, random texts, then a closing text at full rate.
    initial
    begin
        string lead_text;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tlast  = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Lone final byte with nothing held: NUL, one item out with text_end.
        push_byte(8'h00, 1'b1);
        // Empty comment closing right away, number, word, operator run with a trailing
        // dot, then a single quote left open to the end with a high byte inside.
        lead_text = "/**/.5 a_1+=.x\t'";
        text_buf.delete();
        for (int i = 0; i < lead_text.len(); i++)
            text_buf.push_back(lead_text[i]);
        text_buf.push_back(8'hFF);
        send_buf();
        // High single byte, newline, and a slash that ends the text with no lookahead.
        text_buf.delete();
        text_buf.push_back(8'h80);
        text_buf.push_back(CH_NL);
        text_buf.push_back(CH_SLASH);
        send_buf();
        // Double-quoted string spanning a newline, closed on the final byte.
        send_text("\"\n\"");

        // Random texts of tokens and noise; now and then a one-byte text.
        while (bytes_sent < 1150)
        begin
            text_buf.delete();
            repeat ($urandom_range(1, 12)) add_token();
            if ($urandom_range(0, 9) == 0)
                text_buf = text_buf[0:0];
            send_buf();
        end

        // Closing part at full rate: a run of newlines, a word, and a newline to end.
        gaps_on = 1'b0;
        text_buf.delete();
        repeat (20) text_buf.push_back(CH_NL);
        text_buf.push_back("z");
        text_buf.push_back(CH_NL);
        send_buf();
        s_axis_tvalid <= 1'b0;

        // Drain everything still due, then give the pipeline a little time to misbehave.
        while (lexsb.pending() != 0) @(posedge clk);
        repeat (16) @(posedge clk);

        if (lexsb.errors == 0 && lexsb.pending() == 0)
            $display("tb_source_text_lexer: done, clean");
        else
            $display("tb_source_text_lexer: done, errors");
        $finish;
    end

    // Watchdog far beyond the slowest legal run.
    initial
    begin
        #10_000_000;
        $display("tb_source_text_lexer: done, errors");
        $finish;
    end

endmodule
